/* rtl/core/fvn_pkg.sv */
// ----------------------------------------------------------------------------
// fvn_pkg: shared definitions for the fractal value-noise terrain height block
// Widths, fixed-point constants, register codes and reset values used by the
// interfaces, the noise lanes and the top level.
// ----------------------------------------------------------------------------
package fvn_pkg;

	// Port and field widths
	localparam int COORD_W  = 23;
	localparam int HEIGHT_W = 22;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	// Default structural parameters
	localparam int DEF_COS_TABLE_ENTRIES = 256;
	localparam int DEF_MAX_OCTAVES       = 8;

	// Sample position: 8 fraction bits and the 31-bit lattice integer
	localparam int POS_W       = 40;
	localparam int FRAC_W      = 8;
	localparam int FRAC_VALUES = 256;
	localparam logic [POS_W-1:0] POS_OFFSET = 40'd2560000;

	// Floor division by 100 through a reciprocal on a biased value
	localparam int DIV_IN_W  = 24;
	localparam int DIV_Q_W   = 17;
	localparam int DIV_SHIFT = 31;
	localparam int DIV_BIAS  = 4194400;
	localparam logic [24:0] DIV_RECIP = 25'd21474837;
	localparam logic [POS_W-1:0] MTN_POS_OFFSET = 40'd2518056;

	// Lattice hash, computed modulo 2^31
	localparam int LAT_W    = 31;
	localparam int HASH_W   = 32;
	localparam int HASH_ROW = 57;
	localparam int HASH_SHL = 13;
	localparam logic [LAT_W-1:0] HASH_MUL = 31'd15731;
	localparam logic [LAT_W-1:0] HASH_ADD = 31'd789221;
	localparam logic [LAT_W-1:0] HASH_OFS = 31'd1376312589;

	// Raised-cosine weight in Q1.16
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ONE_Q30     = 64'sd1073741824;
	localparam int WEIGHT_W    = 17;
	localparam int WEIGHT_FRAC = 16;
	localparam int WEIGHT_ONE  = 65536;

	// Datapath widths
	localparam int NOISE_W   = 36;
	localparam int NOISE_LAT = 14;
	localparam int TERM_W    = 47;
	localparam int MTN_W     = 38;
	localparam int MTN_PROD_W = 49;
	localparam int BIAS_SHL  = 18;
	localparam int OCT_SH_W  = 7;
	localparam int SUM_W     = 56;
	localparam int OUT_SHIFT = 26;
	localparam int HEIGHT_MAX = 2097151;
	localparam int HEIGHT_MIN = -2097152;

	// Configuration register codes
	typedef enum logic [2:0] {
		REG_OCTAVE_COUNT      = 3'd0,
		REG_BASE_AMPLITUDE    = 3'd1,
		REG_PERSISTENCE_SHIFT = 3'd2,
		REG_MOUNTAIN_GAIN     = 3'd3,
		REG_MOUNTAIN_BIAS     = 3'd4,
		REG_PEAK_GAIN         = 3'd5
	} cfg_reg_t;

	// Reset values
	localparam logic [3:0]         RST_OCTAVE_COUNT      = 4'd4;
	localparam logic [9:0]         RST_BASE_AMPLITUDE    = 10'd120;
	localparam logic [2:0]         RST_PERSISTENCE_SHIFT = 3'd3;
	localparam logic [9:0]         RST_MOUNTAIN_GAIN     = 10'd400;
	localparam logic signed [15:0] RST_MOUNTAIN_BIAS     = 16'sd6554;
	localparam logic [9:0]         RST_PEAK_GAIN         = 10'd50;

endpackage

/* rtl/core/fvn_if.sv */
// ----------------------------------------------------------------------------
// fvn_if: stream channels of the terrain height block
// Coordinate channel in, height channel out; valid/ready with payload.
// ----------------------------------------------------------------------------
interface fvn_coord_if import fvn_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;

	modport source (output valid, output coord_x, output coord_y, input ready);
	modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

interface fvn_height_if import fvn_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [HEIGHT_W-1:0] height;

	modport source (output valid, output height, input ready);
	modport sink   (input valid, input height, output ready);
endinterface

/* rtl/core/fvn_noise.sv */
// ----------------------------------------------------------------------------
// fvn_noise: one pipelined value-noise sample
// Hashes the 4x4 lattice neighbourhood, smooths the four corners and blends
// them with a raised-cosine weight. Fourteen register stages, one sample per
// enabled cycle.
// ----------------------------------------------------------------------------
module fvn_noise import fvn_pkg::*; #(
	parameter int COS_TABLE_ENTRIES = DEF_COS_TABLE_ENTRIES
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [POS_W-1:0]          pos_x,
	input  logic [POS_W-1:0]          pos_y,
	output logic signed [NOISE_W-1:0] noise
);

	localparam int GRID   = 16;
	localparam int LERP_W = NOISE_W + 1 + WEIGHT_W + 1;
	localparam int FX_DLY = 8;
	localparam int FY_DLY = 11;

	// Constant weight table indexed by the 8 fraction bits
	logic [WEIGHT_W-1:0] cos_w [FRAC_VALUES];

	for (genvar f = 0; f < FRAC_VALUES; f++) begin : g_cos
		localparam longint IDX = (longint'(f) * COS_TABLE_ENTRIES) >>> FRAC_W;
		localparam longint A   = HALF_PI_Q30 * IDX / COS_TABLE_ENTRIES;
		localparam longint A2  = (A * A) >>> 30;
		localparam longint T1  = ONE_Q30 - A2 / 72;
		localparam longint T2  = ONE_Q30 - ((A2 * T1) >>> 30) / 42;
		localparam longint T3  = ONE_Q30 - ((A2 * T2) >>> 30) / 20;
		localparam longint T4  = ONE_Q30 - ((A2 * T3) >>> 30) / 6;
		localparam longint S   = (A * T4) >>> 30;
		localparam longint G   = (S * S + (longint'(1) <<< 43)) >>> 44;
		localparam longint GC  = (G > WEIGHT_ONE) ? WEIGHT_ONE : ((G < 0) ? 0 : G);
		assign cos_w[f] = WEIGHT_W'(GC);
	end

	logic [LAT_W-1:0] ix, iy, iy57;
	logic [LAT_W-1:0] base_s1;
	logic [FRAC_W-1:0] fx_q [FX_DLY];
	logic [FRAC_W-1:0] fy_q [FY_DLY];
	logic [LAT_W-1:0] hm_s2 [GRID];
	logic [LAT_W-1:0] hm_s3 [GRID];
	logic [LAT_W-1:0] sq_s3 [GRID];
	logic [LAT_W-1:0] hm_s4 [GRID];
	logic [LAT_W-1:0] pl_s4 [GRID];
	logic [LAT_W-1:0] t_s5 [GRID];
	logic signed [HASH_W-1:0] h_s6 [GRID];
	logic signed [HASH_W+1:0] cs_s7 [4];
	logic signed [HASH_W+1:0] ss_s7 [4];
	logic signed [HASH_W-1:0] ctr_s7 [4];
	logic signed [NOISE_W-1:0] v_s8 [4];
	logic signed [NOISE_W:0] d_s9 [2];
	logic signed [NOISE_W-1:0] a_s9 [2];
	logic [WEIGHT_W-1:0] wx_s9;
	logic signed [LERP_W-1:0] p_s10 [2];
	logic signed [NOISE_W-1:0] a_s10 [2];
	logic signed [NOISE_W-1:0] l_s11 [2];
	logic signed [NOISE_W:0] d_s12;
	logic signed [NOISE_W-1:0] a_s12;
	logic [WEIGHT_W-1:0] wy_s12;
	logic signed [LERP_W-1:0] p_s13;
	logic signed [NOISE_W-1:0] a_s13;
	logic signed [NOISE_W-1:0] noise_s14;

	assign ix   = pos_x[FRAC_W+LAT_W-1:FRAC_W];
	assign iy   = pos_y[FRAC_W+LAT_W-1:FRAC_W];
	assign iy57 = iy * LAT_W'(HASH_ROW);

	// Stage 1: hash base of the lattice point, hold fractions
	always_ff @(posedge clk) begin
		if (en) begin
			base_s1 <= ix + iy57;
			fx_q[0] <= pos_x[FRAC_W-1:0];
			fy_q[0] <= pos_y[FRAC_W-1:0];
			for (int k = 1; k < FX_DLY; k++) fx_q[k] <= fx_q[k-1];
			for (int k = 1; k < FY_DLY; k++) fy_q[k] <= fy_q[k-1];
		end
	end

	// Stages 2 to 6: sixteen hash lanes over the neighbourhood
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 4; j++) begin
				for (int i = 0; i < 4; i++) begin
					hm_s2[4*j+i] <= (base_s1 + LAT_W'((i - 1) + HASH_ROW * (j - 1)))
						^ ((base_s1 + LAT_W'((i - 1) + HASH_ROW * (j - 1))) << HASH_SHL);
				end
			end
			for (int g = 0; g < GRID; g++) begin
				sq_s3[g] <= hm_s2[g] * hm_s2[g];
				hm_s3[g] <= hm_s2[g];
				pl_s4[g] <= sq_s3[g] * HASH_MUL + HASH_ADD;
				hm_s4[g] <= hm_s3[g];
				t_s5[g]  <= hm_s4[g] * pl_s4[g] + HASH_OFS;
				h_s6[g]  <= $signed(HASH_W'(ONE_Q30)) - $signed({1'b0, t_s5[g]});
			end
		end
	end

	// Stages 7 and 8: smooth the four corners (corners + 2*sides + 4*center)
	always_ff @(posedge clk) begin
		if (en) begin
			for (int cy = 0; cy < 2; cy++) begin
				for (int cx = 0; cx < 2; cx++) begin
					cs_s7[2*cy+cx] <= (HASH_W+2)'(h_s6[4*cy+cx]) + (HASH_W+2)'(h_s6[4*cy+cx+2])
						+ (HASH_W+2)'(h_s6[4*(cy+2)+cx]) + (HASH_W+2)'(h_s6[4*(cy+2)+cx+2]);
					ss_s7[2*cy+cx] <= (HASH_W+2)'(h_s6[4*cy+cx+1]) + (HASH_W+2)'(h_s6[4*(cy+1)+cx])
						+ (HASH_W+2)'(h_s6[4*(cy+1)+cx+2]) + (HASH_W+2)'(h_s6[4*(cy+2)+cx+1]);
					ctr_s7[2*cy+cx] <= h_s6[4*(cy+1)+cx+1];
				end
			end
			for (int c = 0; c < 4; c++) begin
				v_s8[c] <= NOISE_W'(cs_s7[c]) + (NOISE_W'(ss_s7[c]) <<< 1)
					+ (NOISE_W'(ctr_s7[c]) <<< 2);
			end
		end
	end

	// Stages 9 to 11: blend along x for both rows
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				d_s9[k]  <= (NOISE_W+1)'(v_s8[2*k+1]) - (NOISE_W+1)'(v_s8[2*k]);
				a_s9[k]  <= v_s8[2*k];
				p_s10[k] <= d_s9[k] * $signed({1'b0, wx_s9});
				a_s10[k] <= a_s9[k];
				l_s11[k] <= NOISE_W'(LERP_W'(a_s10[k]) + (p_s10[k] >>> WEIGHT_FRAC));
			end
			wx_s9 <= cos_w[fx_q[FX_DLY-1]];
		end
	end

	// Stages 12 to 14: blend along y
	always_ff @(posedge clk) begin
		if (en) begin
			d_s12     <= (NOISE_W+1)'(l_s11[1]) - (NOISE_W+1)'(l_s11[0]);
			a_s12     <= l_s11[0];
			wy_s12    <= cos_w[fy_q[FY_DLY-1]];
			p_s13     <= d_s12 * $signed({1'b0, wy_s12});
			a_s13     <= a_s12;
			noise_s14 <= NOISE_W'(LERP_W'(a_s13) + (p_s13 >>> WEIGHT_FRAC));
		end
	end

	assign noise = noise_s14;

endmodule

/* rtl/core/fractal_value_noise_terrain_height.sv */
// ----------------------------------------------------------------------------
// fractal_value_noise_terrain_height: streaming terrain height generator
// Turns a Q15.8 world coordinate pair into a saturated Q14.8 height from a
// base fractal, a mountain term and a peak term of value noise.
// ----------------------------------------------------------------------------
// Usage:
//   sample carries one coordinate pair per transaction, result one height.
//   Both are valid/ready channels; the block keeps no state between samples.
//   Six configuration registers sit on the APB port at byte address 4*index;
//   write them only while no sample is in flight.
// Throughput: one sample per cycle while the output buffer has room. Every
//   octave and the mountain noise run in parallel lanes of the same
//   pipeline; the peak term reuses the first octave's noise.
// Path: an accepted sample passes the coordinate stage, the position stage,
//   the 14-stage noise lanes, the amplitude stage and the registered adder
//   tree before its height enters the output buffer; result.valid rises as
//   the height enters that buffer.
// Stall: a two-entry output buffer takes the finished heights. The pipeline
//   and sample.ready stop only while that buffer is full, so a sample is
//   still taken while one height waits to be read.
// Reset: arst_n clears the pipeline valid bits and the buffer and loads the
//   register defaults; there is no clearing pass.
module fractal_value_noise_terrain_height import fvn_pkg::*; #(
	parameter int COS_TABLE_ENTRIES = DEF_COS_TABLE_ENTRIES,
	parameter int MAX_OCTAVES       = DEF_MAX_OCTAVES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	fvn_coord_if.sink         sample,
	fvn_height_if.source      result
);

	localparam int LANES    = MAX_OCTAVES + 1;
	localparam int MTN_LANE = MAX_OCTAVES;
	localparam int TERMS    = MAX_OCTAVES + 2;
	localparam int LEVELS   = $clog2(TERMS);
	localparam int LEAVES   = 1 << LEVELS;
	localparam int DEPTH    = 2 + NOISE_LAT + 2 + LEVELS;
	localparam int HQ_W     = SUM_W - OUT_SHIFT;

	logic [3:0]         octave_count_q;
	logic [9:0]         base_amplitude_q;
	logic [2:0]         persistence_shift_q;
	logic [9:0]         mountain_gain_q;
	logic signed [15:0] mountain_bias_q;
	logic [9:0]         peak_gain_q;
	cfg_reg_t           cfg_idx;

	logic                       en;
	logic [DEPTH-1:0]           vld_q;
	logic [1:0]                 cnt_q;
	logic signed [HEIGHT_W-1:0] buf0_q, buf1_q;
	logic                       push, pop;

	logic [DIV_IN_W:0]          ux_w, uy_w;
	logic [48:0]                mx_prod, my_prod;
	logic signed [COORD_W-1:0]  x_s1, y_s1;
	logic [48:0]                mx_s1, my_s1;

	logic signed [NOISE_W-1:0] noise_s16 [LANES];
	logic signed [SUM_W-1:0]   leaf_d [LEAVES];
	logic signed [MTN_W-1:0]   mval;
	logic signed [TERM_W-1:0]  pk_prod;
	logic signed [MTN_W-1:0]   m_s17;
	logic signed [TERM_W-1:0]  pk_s17;
	logic signed [MTN_PROD_W-1:0] m_prod;
	logic signed [SUM_W-1:0]   tree_s18 [LEVELS+1][LEAVES];
	logic signed [HQ_W-1:0]    hq;
	logic signed [HEIGHT_W-1:0] hsat;

	// Configuration port
	assign pready  = 1'b1;
	assign cfg_idx = cfg_reg_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q      <= RST_OCTAVE_COUNT;
			base_amplitude_q    <= RST_BASE_AMPLITUDE;
			persistence_shift_q <= RST_PERSISTENCE_SHIFT;
			mountain_gain_q     <= RST_MOUNTAIN_GAIN;
			mountain_bias_q     <= RST_MOUNTAIN_BIAS;
			peak_gain_q         <= RST_PEAK_GAIN;
		end else if (psel && penable && pwrite) begin
			unique case (cfg_idx)
				REG_OCTAVE_COUNT:      octave_count_q      <= pwdata[3:0];
				REG_BASE_AMPLITUDE:    base_amplitude_q    <= pwdata[9:0];
				REG_PERSISTENCE_SHIFT: persistence_shift_q <= pwdata[2:0];
				REG_MOUNTAIN_GAIN:     mountain_gain_q     <= pwdata[9:0];
				REG_MOUNTAIN_BIAS:     mountain_bias_q     <= $signed(pwdata[15:0]);
				REG_PEAK_GAIN:         peak_gain_q         <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_OCTAVE_COUNT:      prdata = DATA_W'(octave_count_q);
			REG_BASE_AMPLITUDE:    prdata = DATA_W'(base_amplitude_q);
			REG_PERSISTENCE_SHIFT: prdata = DATA_W'(persistence_shift_q);
			REG_MOUNTAIN_GAIN:     prdata = DATA_W'(mountain_gain_q);
			REG_MOUNTAIN_BIAS:     prdata = DATA_W'(unsigned'(mountain_bias_q));
			REG_PEAK_GAIN:         prdata = DATA_W'(peak_gain_q);
			default:               prdata = '0;
		endcase
	end

	// Advance the whole pipeline while the output buffer has room
	assign en           = (cnt_q != 2'd2);
	assign sample.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], sample.valid};
		end
	end

	// Stage 1: hold coordinates, multiply the biased values by 1/100
	assign ux_w    = (DIV_IN_W+1)'(sample.coord_x) + (DIV_IN_W+1)'(DIV_BIAS);
	assign uy_w    = (DIV_IN_W+1)'(sample.coord_y) + (DIV_IN_W+1)'(DIV_BIAS);
	assign mx_prod = 49'(ux_w[DIV_IN_W-1:0]) * 49'(DIV_RECIP);
	assign my_prod = 49'(uy_w[DIV_IN_W-1:0]) * 49'(DIV_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= sample.coord_x;
			y_s1  <= sample.coord_y;
			mx_s1 <= mx_prod;
			my_s1 <= my_prod;
		end
	end

	// Stage 2 and noise lanes: octave positions scale by powers of two
	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
		logic signed [POS_W-1:0] sx, sy;
		logic [POS_W-1:0]        px_s2, py_s2;

		if (i < 4) begin : g_down
			assign sx = POS_W'(x_s1) >>> (4 - i);
			assign sy = POS_W'(y_s1) >>> (4 - i);
		end else begin : g_up
			assign sx = POS_W'(x_s1) <<< (i - 4);
			assign sy = POS_W'(y_s1) <<< (i - 4);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				px_s2 <= unsigned'(sx) + POS_OFFSET;
				py_s2 <= unsigned'(sy) + POS_OFFSET;
			end
		end

		fvn_noise #(.COS_TABLE_ENTRIES(COS_TABLE_ENTRIES)) u_noise (
			.clk   (clk),
			.en    (en),
			.pos_x (px_s2),
			.pos_y (py_s2),
			.noise (noise_s16[i])
		);
	end

	// Mountain lane at 1/100 of the coordinates
	logic [POS_W-1:0] mpx_s2, mpy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			mpx_s2 <= POS_W'(mx_s1[DIV_SHIFT+DIV_Q_W-1:DIV_SHIFT]) + MTN_POS_OFFSET;
			mpy_s2 <= POS_W'(my_s1[DIV_SHIFT+DIV_Q_W-1:DIV_SHIFT]) + MTN_POS_OFFSET;
		end
	end

	fvn_noise #(.COS_TABLE_ENTRIES(COS_TABLE_ENTRIES)) u_mtn_noise (
		.clk   (clk),
		.en    (en),
		.pos_x (mpx_s2),
		.pos_y (mpy_s2),
		.noise (noise_s16[MTN_LANE])
	);

	// Stage 17: octave amplitude products, mountain bias, peak gain
	// (the peak noise is the first octave's noise)
	assign mval    = MTN_W'(noise_s16[MTN_LANE]) + (MTN_W'(mountain_bias_q) <<< BIAS_SHL);
	assign pk_prod = noise_s16[0] * $signed({1'b0, peak_gain_q});

	always_ff @(posedge clk) begin
		if (en) begin
			m_s17  <= mval;
			pk_s17 <= pk_prod;
		end
	end

	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_term
		logic signed [TERM_W-1:0] prod, prod_s17;
		logic [OCT_SH_W-1:0]      sh;

		assign prod = noise_s16[i] * $signed({1'b0, base_amplitude_q});
		assign sh   = OCT_SH_W'(int'(persistence_shift_q) * (i + 1));

		always_ff @(posedge clk) begin
			if (en) prod_s17 <= prod;
		end

		// Drop octaves beyond the configured count
		assign leaf_d[i] = (i < int'(octave_count_q)) ? SUM_W'(prod_s17 >>> sh) : '0;
	end

	// Keep mountain only where its sum is positive; peak needs a positive peak too
	assign m_prod = m_s17 * $signed({1'b0, mountain_gain_q});
	assign leaf_d[MAX_OCTAVES] = (m_s17 > 0) ? SUM_W'(m_prod) : '0;
	assign leaf_d[MAX_OCTAVES+1] = ((m_s17 > 0) && (pk_s17 > 0)) ? SUM_W'(pk_s17) : '0;

	for (genvar k = TERMS; k < LEAVES; k++) begin : g_pad
		assign leaf_d[k] = '0;
	end

	// Stage 18 onward: registered adder tree, one level per stage
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < LEAVES; k++) tree_s18[0][k] <= leaf_d[k];
			for (int l = 1; l <= LEVELS; l++) begin
				for (int k = 0; k < (LEAVES >> l); k++) begin
					tree_s18[l][k] <= tree_s18[l-1][2*k] + tree_s18[l-1][2*k+1];
				end
			end
		end
	end

	// Scale to Q14.8 and saturate
	assign hq = HQ_W'(tree_s18[LEVELS][0] >>> OUT_SHIFT);

	always_comb begin
		if (hq > HQ_W'(HEIGHT_MAX)) begin
			hsat = HEIGHT_W'(HEIGHT_MAX);
		end else if (hq < HQ_W'(HEIGHT_MIN)) begin
			hsat = HEIGHT_W'(HEIGHT_MIN);
		end else begin
			hsat = HEIGHT_W'(hq);
		end
	end

	// Two-entry output buffer
	assign push          = en && vld_q[DEPTH-1];
	assign pop           = (cnt_q != 2'd0) && result.ready;
	assign result.valid  = (cnt_q != 2'd0);
	assign result.height = buf0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// Load the head from the pipeline when it is empty or just read, else shift up
	always_ff @(posedge clk) begin
		if (push && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop))) begin
			buf0_q <= hsat;
		end else if (pop) begin
			buf0_q <= buf1_q;
		end
		if (push && (cnt_q == 2'd1) && !pop) begin
			buf1_q <= hsat;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline valid bits moved during a stall");

	a_pop_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (cnt_q == $past(cnt_q) - 2'd1))
		else $error("output buffer count did not drop after a read");

	a_push_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("output buffer count did not grow after a write");
`endif

endmodule
